@@ src/base64_codec_unpadded_assert.svh @@
// Assertion macros used by the checker file of the base64 codec.
// No dependencies; include this file inside a module body.
`ifndef BASE64_CODEC_UNPADDED_ASSERT_SVH
`define BASE64_CODEC_UNPADDED_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64U_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64U_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/b64u_pkg.sv @@
// Types, constants and alphabet functions of the unpadded base64 codec.
// No dependencies; used by b64u_step and base64_codec_unpadded.
`default_nettype none

package b64u_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;
    localparam logic [5:0] SIX_MASK     = 6'h3f;

    localparam logic [6:0] SEXTET_INVALID = 7'd64;

    // Message state: at most six pending bits are ever held between items.
    typedef struct packed {
        logic [5:0] acc;
        logic [2:0] pend;
        logic       err;
    } b64u_state_t;

    // One result item, out_value in the low bits.
    typedef struct packed {
        logic       eom;
        logic       last_of_run;
        logic       status;
        logic       has_data;
        logic [7:0] out_value;
    } b64u_result_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        begin
            w = {2'b00, v & SIX_MASK};
            if (w < 8'd26) begin
                c = CHAR_UPPER_A + w;
            end else if (w < 8'd52) begin
                c = CHAR_LOWER_A + (w - 8'd26);
            end else if (w < 8'd62) begin
                c = CHAR_DIGIT_0 + (w - 8'd52);
            end else if (w == 8'd62) begin
                c = CHAR_PLUS;
            end else begin
                c = CHAR_SLASH;
            end
            return c;
        end
    endfunction

    // Six-bit value of an alphabet character, SEXTET_INVALID otherwise.
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        logic [7:0] v;
        begin
            case (c) inside
                [8'h41:8'h5a]: v = c - CHAR_UPPER_A;
                [8'h61:8'h7a]: v = c - CHAR_LOWER_A + 8'd26;
                [8'h30:8'h39]: v = c - CHAR_DIGIT_0 + 8'd52;
                CHAR_PLUS:     v = 8'd62;
                CHAR_SLASH:    v = 8'd63;
                default:       v = {1'b0, SEXTET_INVALID};
            endcase
            return v[6:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ src/base64_codec_unpadded.sv @@
// Top level of the unpadded base64 codec: message state, mode register and
// a two-entry result buffer. Depends on b64u_pkg and b64u_step.
//
//  channel  direction  tdata                          tuser              tlast
//  s_       in         data_in[7:0]                   -                  last_in
//  m_       out        out_value[7:0], last_of_run    has_data, status   end_of_message
//  cfg_     in         mode (cfg_data)                -                  -
//
// An item is taken in a cycle with s_tready high; its results, none, one or two,
// sit in the result buffer and leave one per cycle while m_tready is high, so
// the next item waits until the last of them is leaving.
// The result buffer's single output port sets that rate.
// Reset (aresetn low, synchronous) selects encode mode and clears the message.
// s_tready stays high while the buffer is empty or its last entry is leaving,
// and drops while a mode write waits; a mode write needs an empty buffer.
`default_nettype none

module base64_codec_unpadded (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_in
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_value, [8] last_of_run, [15:9] zero
    output logic [1:0]       m_tuser,   // [0] has_data, [1] status
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);
    import b64u_pkg::*;

    logic         mode_reg;
    b64u_state_t  state_reg;
    b64u_state_t  state_next;
    b64u_result_t head_reg;
    b64u_result_t tail_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   step_num;
    b64u_result_t step_res0;
    b64u_result_t step_res1;
    logic         in_xfer;
    logic         out_xfer;
    logic         cfg_xfer;

    b64u_step u_step (
        .mode (mode_reg),
        .cur  (state_reg),
        .data (s_tdata),
        .last (s_tlast),
        .nxt  (state_next),
        .num  (step_num),
        .res0 (step_res0),
        .res1 (step_res1)
    );

    // mode writes only with nothing in flight and no input transaction alongside
    assign cfg_ready = (cnt_reg == 2'd0);
    assign cfg_xfer  = cfg_valid && cfg_ready;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign s_tready = !cfg_valid && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready));
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    assign m_tdata = {7'b0000000, head_reg.last_of_run, head_reg.out_value};
    assign m_tuser = {head_reg.status, head_reg.has_data};
    assign m_tlast = head_reg.eom;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_ENCODE;
            state_reg <= '0;
            cnt_reg   <= 2'd0;
        end else begin
            if (cfg_xfer) begin
                // a mode write abandons any message in progress
                mode_reg  <= cfg_data;
                state_reg <= '0;
            end else if (in_xfer) begin
                state_reg <= state_next;
            end

            if (in_xfer) begin
                cnt_reg <= step_num;
            end else if (out_xfer) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            head_reg <= step_res0;
            tail_reg <= step_res1;
        end else if (out_xfer && (cnt_reg == 2'd2)) begin
            head_reg <= tail_reg;
        end
    end

endmodule

`default_nettype wire

@@ src/b64u_step.sv @@
// Combinational datapath of the codec: one item against the message state,
// giving the next state and up to two results. Depends on b64u_pkg.
`default_nettype none

module b64u_step (
    input  wire logic                 mode,
    input  wire b64u_pkg::b64u_state_t cur,
    input  wire logic [7:0]           data,
    input  wire logic                 last,
    output b64u_pkg::b64u_state_t     nxt,
    output logic [1:0]                num,
    output b64u_pkg::b64u_result_t    res0,
    output b64u_pkg::b64u_result_t    res1
);
    import b64u_pkg::*;

    logic [6:0] sext;

    assign sext = char_sextet(data);

    always_comb begin
        nxt  = cur;
        num  = 2'd0;
        res0 = '0;
        res1 = '0;

        if (mode == MODE_ENCODE) begin
            res0.has_data = 1'b1;
            res1.has_data = 1'b1;
            case (cur.pend)
                3'd2: begin
                    res0.out_value = sextet_char({cur.acc[1:0], data[7:4]});
                    res1.out_value = sextet_char({data[3:0], 2'b00});
                    num            = last ? 2'd2 : 2'd1;
                    nxt.acc        = {2'b00, data[3:0]};
                    nxt.pend       = 3'd4;
                end
                3'd4: begin
                    res0.out_value = sextet_char({cur.acc[3:0], data[7:6]});
                    res1.out_value = sextet_char(data[5:0]);
                    num            = 2'd2;
                    nxt.acc        = '0;
                    nxt.pend       = 3'd0;
                end
                default: begin
                    res0.out_value = sextet_char(data[7:2]);
                    res1.out_value = sextet_char({data[1:0], 4'b0000});
                    num            = last ? 2'd2 : 2'd1;
                    nxt.acc        = {4'b0000, data[1:0]};
                    nxt.pend       = 3'd2;
                end
            endcase
        end else if (cur.err) begin
            // rest of a bad message: only its end reports
            res0.status = 1'b1;
            num         = last ? 2'd1 : 2'd0;
        end else if (sext == SEXTET_INVALID) begin
            res0.status = 1'b1;
            num         = 2'd1;
            nxt.err     = 1'b1;
        end else begin
            res0.has_data = 1'b1;
            num           = 2'd1;
            case (cur.pend)
                3'd2: begin
                    res0.out_value = {cur.acc[1:0], sext[5:0]};
                    nxt.acc        = '0;
                    nxt.pend       = 3'd0;
                end
                3'd4: begin
                    res0.out_value = {cur.acc[3:0], sext[5:2]};
                    nxt.acc        = {4'b0000, sext[1:0]};
                    nxt.pend       = 3'd2;
                end
                3'd6: begin
                    res0.out_value = {cur.acc[5:0], sext[5:4]};
                    nxt.acc        = {2'b00, sext[3:0]};
                    nxt.pend       = 3'd4;
                end
                default: begin
                    // six bits only, no byte yet; an empty end marker if last
                    res0.has_data = 1'b0;
                    num           = last ? 2'd1 : 2'd0;
                    nxt.acc       = sext[5:0];
                    nxt.pend      = 3'd6;
                end
            endcase
        end

        if (num == 2'd2) begin
            res1.last_of_run = 1'b1;
            res1.eom         = last;
        end else begin
            res0.last_of_run = 1'b1;
            res0.eom         = last;
        end

        if (last) begin
            nxt = '0;
        end
    end

endmodule

`default_nettype wire

@@ src/b64u_checker.sv @@
// Port-level checks on the result channel of the base64 codec, bound to the
// top level. Depends on base64_codec_unpadded_assert.svh.
`default_nettype none

module b64u_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    `include "base64_codec_unpadded_assert.svh"

    `B64U_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")
    `B64U_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[7:0] == 8'h00, "nonzero value without data")
    `B64U_ASSERT_NOW(a_eom_run, aclk, aresetn, m_tvalid && m_tlast, m_tdata[8], "message end not marked as end of run")
    `B64U_ASSERT_NOW(a_bad_nodata, aclk, aresetn, m_tvalid && m_tuser[1], !m_tuser[0], "bad character result carries data")

endmodule

bind base64_codec_unpadded b64u_checker u_b64u_checker (.*);

`default_nettype wire
